[hw/rtl/gcgb_pkg.sv]
// Package: screen geometry, palette sizing, color constants and channel blend functions.
package gcgb_pkg;

  localparam int SCREEN_WIDTH  = 1920;
  localparam int SCREEN_HEIGHT = 1080;
  localparam int PALETTE_STEPS = 8;

  localparam int ORIGIN_W  = 13;
  localparam int GLYPH_W   = 8;
  localparam int COV_W     = 8;
  localparam int ADDR_W    = 21;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam int POS_W      = ORIGIN_W + 1;
  localparam int SCR_IDX_W  = 12;
  localparam int SCR_W_W    = $clog2(SCREEN_WIDTH + 1);
  localparam int ADDR_FULL_W = SCR_IDX_W + SCR_W_W + 1;

  localparam int PAL_MAX   = PALETTE_STEPS - 1;
  localparam int K_W       = $clog2(PALETTE_STEPS);
  localparam int NUM_W     = $clog2(255 * PAL_MAX + 1);
  localparam int NUM_SW    = NUM_W + 2;
  localparam int DIV_SH    = NUM_W + 4;
  localparam int DIV_RECIP = (2 ** DIV_SH + PAL_MAX - 1) / PAL_MAX;
  localparam int PROD_W    = NUM_W + DIV_SH + 1;

  localparam int ROW_RECIP = 171;
  localparam int ROW_SH    = 9;
  localparam int ROW_PROD_W = GLYPH_W + 8;
  localparam int ROW_Q_W   = ROW_PROD_W - ROW_SH;

  localparam logic [COLOR_W-1:0] GRAY_COLOR   = 32'hFF80_8080;
  localparam logic [COV_W-1:0]   COVERAGE_MID = 8'h80;
  localparam logic [COV_W-1:0]   COVERAGE_NONE = 8'h00;

  localparam logic [COLOR_W-1:0] START_COLOR_RST = 32'hFFFF_0000;
  localparam logic [COLOR_W-1:0] END_COLOR_RST   = 32'hFF00_00FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_COLOR = 1'b0,
    REG_END_COLOR   = 1'b1
  } cfg_reg_t;

  typedef logic [COLOR_W-1:0] color_t;

  function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] e,
                                               input logic [K_W-1:0] k);
    logic signed [NUM_SW-1:0] s_x;
    logic signed [NUM_SW-1:0] e_x;
    logic signed [NUM_SW-1:0] k_x;
    logic signed [NUM_SW-1:0] num;
    logic [PROD_W-1:0] prod;
    s_x  = NUM_SW'(s);
    e_x  = NUM_SW'(e);
    k_x  = NUM_SW'(k);
    num  = s_x * NUM_SW'(PAL_MAX) + (e_x - s_x) * k_x;
    prod = PROD_W'(num[NUM_W-1:0]) * PROD_W'(DIV_RECIP);
    return prod[DIV_SH +: 8];
  endfunction

  function automatic color_t palette_color(input color_t s, input color_t e,
                                           input logic [K_W-1:0] k);
    color_t c;
    c = '0;
    for (int ch = 0; ch < 4; ch++) begin
      c[ch*8 +: 8] = blend_channel(s[ch*8 +: 8], e[ch*8 +: 8], k);
    end
    return c;
  endfunction

endpackage

[hw/rtl/gcgb_palette.sv]
// Gradient palette: color registers, precomputed palette entries and entry select.
module gcgb_palette (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gcgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcgb_pkg::COLOR_W-1:0]    cfg_wdata,
  input  logic [gcgb_pkg::K_W-1:0]        entry_k,
  output gcgb_pkg::color_t                entry_color
);

  gcgb_pkg::color_t start_r;
  gcgb_pkg::color_t end_r;
  gcgb_pkg::color_t start_nxt;
  gcgb_pkg::color_t end_nxt;
  gcgb_pkg::color_t palette_r [gcgb_pkg::PALETTE_STEPS];

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    if (cfg_we) begin
      unique case (gcgb_pkg::cfg_reg_t'(cfg_index))
        gcgb_pkg::REG_START_COLOR: start_nxt = cfg_wdata;
        gcgb_pkg::REG_END_COLOR:   end_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= gcgb_pkg::START_COLOR_RST;
      end_r   <= gcgb_pkg::END_COLOR_RST;
      for (int i = 0; i < gcgb_pkg::PALETTE_STEPS; i++) begin
        palette_r[i] <= gcgb_pkg::palette_color(gcgb_pkg::START_COLOR_RST,
                                                gcgb_pkg::END_COLOR_RST,
                                                gcgb_pkg::K_W'(i));
      end
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      for (int i = 0; i < gcgb_pkg::PALETTE_STEPS; i++) begin
        palette_r[i] <= gcgb_pkg::palette_color(start_nxt, end_nxt, gcgb_pkg::K_W'(i));
      end
    end
  end

  assign entry_color = palette_r[entry_k];

endmodule

[hw/rtl/glyph_coverage_gradient_blit.sv]
// Top level: glyph coverage pixel to framebuffer write, with gradient palette coloring.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   origin_x, origin_y, glyph_col, glyph_row, coverage
//   out_     output     out_valid/out_ready pixel_address, pixel_color
//   cfg_     input      cfg_we              cfg_index, cfg_wdata (start_color, end_color)
//
// One transaction per cycle while the result is not stalled; the result register loads from the input register.
// Off-screen pixels and coverage 0 or 0x80 leave the input register without a result.
// Palette entries are registered and refreshed in the same edge as a color write.
// Synchronous active-low reset clears valids and restores the default gradient.
// A stalled result holds the output register; the input register drains when it carries
// no result.
module glyph_coverage_gradient_blit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [gcgb_pkg::ORIGIN_W-1:0] in_origin_x,
  input  logic signed [gcgb_pkg::ORIGIN_W-1:0] in_origin_y,
  input  logic [gcgb_pkg::GLYPH_W-1:0]    in_glyph_col,
  input  logic [gcgb_pkg::GLYPH_W-1:0]    in_glyph_row,
  input  logic [gcgb_pkg::COV_W-1:0]      in_coverage,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gcgb_pkg::ADDR_W-1:0]     out_pixel_address,
  output logic [gcgb_pkg::COLOR_W-1:0]    out_pixel_color,
  input  logic                            cfg_we,
  input  logic [gcgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcgb_pkg::COLOR_W-1:0]    cfg_wdata
);

  logic                                   s1_v_r;
  logic signed [gcgb_pkg::ORIGIN_W-1:0]   ox_r;
  logic signed [gcgb_pkg::ORIGIN_W-1:0]   oy_r;
  logic [gcgb_pkg::GLYPH_W-1:0]           col_r;
  logic [gcgb_pkg::GLYPH_W-1:0]           row_r;
  logic [gcgb_pkg::COV_W-1:0]             cov_r;

  logic                                   out_v_r;
  logic [gcgb_pkg::ADDR_W-1:0]            addr_r;
  gcgb_pkg::color_t                       color_r;

  logic signed [gcgb_pkg::POS_W-1:0]      sx;
  logic signed [gcgb_pkg::POS_W-1:0]      sy;
  logic                                   on_screen;
  logic                                   cov_gray;
  logic                                   cov_grad;
  logic                                   keep;
  logic [gcgb_pkg::ROW_PROD_W-1:0]        row_prod;
  logic [gcgb_pkg::ROW_Q_W-1:0]           row_q;
  logic [gcgb_pkg::K_W-1:0]               pal_k;
  gcgb_pkg::color_t                       pal_color;
  logic [gcgb_pkg::ADDR_FULL_W-1:0]       addr_full;
  logic                                   out_free;

  assign sx = gcgb_pkg::POS_W'(ox_r) + $signed(gcgb_pkg::POS_W'(col_r));
  assign sy = gcgb_pkg::POS_W'(oy_r) + $signed(gcgb_pkg::POS_W'(row_r));

  assign on_screen = (sx >= 0) && (sx < gcgb_pkg::POS_W'(gcgb_pkg::SCREEN_WIDTH)) &&
                     (sy >= 0) && (sy < gcgb_pkg::POS_W'(gcgb_pkg::SCREEN_HEIGHT));

  assign cov_gray = (cov_r != gcgb_pkg::COVERAGE_NONE) && (cov_r < gcgb_pkg::COVERAGE_MID);
  assign cov_grad = cov_r > gcgb_pkg::COVERAGE_MID;
  assign keep     = on_screen && (cov_gray || cov_grad);

  assign row_prod = gcgb_pkg::ROW_PROD_W'(row_r) *
                    gcgb_pkg::ROW_PROD_W'(gcgb_pkg::ROW_RECIP);
  assign row_q    = row_prod[gcgb_pkg::ROW_PROD_W-1:gcgb_pkg::ROW_SH];
  assign pal_k    = (row_q > gcgb_pkg::ROW_Q_W'(gcgb_pkg::PAL_MAX)) ?
                    gcgb_pkg::K_W'(gcgb_pkg::PAL_MAX) : row_q[gcgb_pkg::K_W-1:0];

  assign addr_full = gcgb_pkg::ADDR_FULL_W'(sy[gcgb_pkg::SCR_IDX_W-1:0]) *
                     gcgb_pkg::ADDR_FULL_W'(gcgb_pkg::SCREEN_WIDTH) +
                     gcgb_pkg::ADDR_FULL_W'(sx[gcgb_pkg::SCR_IDX_W-1:0]);

  gcgb_palette u_palette (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .entry_k     (pal_k),
    .entry_color (pal_color)
  );

  assign out_free = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || !keep || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ox_r  <= in_origin_x;
      oy_r  <= in_origin_y;
      col_r <= in_glyph_col;
      row_r <= in_glyph_row;
      cov_r <= in_coverage;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_v_r && keep) begin
      addr_r  <= addr_full[gcgb_pkg::ADDR_W-1:0];
      color_r <= cov_gray ? gcgb_pkg::GRAY_COLOR : pal_color;
    end
  end

  assign out_valid         = out_v_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;

endmodule

[dv/tb_glyph_coverage_gradient_blit.sv]
// Testbench for the glyph coverage blitter: directed and random pixels against a gradient predictor.
`timescale 1ns / 1ps

module tb_glyph_coverage_gradient_blit;
  import gcgb_pkg::*;

  localparam int PAL_LAST     = PALETTE_STEPS - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [GLYPH_W-1:0]         glyph_col;
    logic [GLYPH_W-1:0]         glyph_row;
    logic [COV_W-1:0]           coverage;
  } glyph_pixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
  } pixel_write_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [ORIGIN_W-1:0]  in_origin_x = '0;
  logic signed [ORIGIN_W-1:0]  in_origin_y = '0;
  logic [GLYPH_W-1:0]          in_glyph_col = '0;
  logic [GLYPH_W-1:0]          in_glyph_row = '0;
  logic [COV_W-1:0]            in_coverage = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ADDR_W-1:0]           out_pixel_address;
  logic [COLOR_W-1:0]          out_pixel_color;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [COLOR_W-1:0]          cfg_wdata = '0;

  logic [COLOR_W-1:0] grad_start = START_COLOR_RST;
  logic [COLOR_W-1:0] grad_end   = END_COLOR_RST;
  pixel_write_t       pending_writes[$];
  int                 mismatches = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 30;
  int                 sink_stall_pct = 63;

  glyph_coverage_gradient_blit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_origin_x       (in_origin_x),
    .in_origin_y       (in_origin_y),
    .in_glyph_col      (in_glyph_col),
    .in_glyph_row      (in_glyph_row),
    .in_coverage       (in_coverage),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  function automatic logic [7:0] blend_lane(input int s, input int e, input int k);
    int num;
    num = s * PAL_LAST + (e - s) * k;
    if (num < 0) num = 0;
    return 8'(num / PAL_LAST);
  endfunction

  function automatic bit predict_write(input glyph_pixel_t p, output pixel_write_t w);
    int sx;
    int sy;
    int k;
    int ox_i;
    int oy_i;
    logic [COLOR_W-1:0] shade;
    ox_i = p.origin_x;
    oy_i = p.origin_y;
    sx = ox_i + int'(p.glyph_col);
    sy = oy_i + int'(p.glyph_row);
    w = '0;
    if (sx < 0 || sx >= SCREEN_WIDTH || sy < 0 || sy >= SCREEN_HEIGHT) return 1'b0;
    if (p.coverage == COVERAGE_NONE || p.coverage == COVERAGE_MID) return 1'b0;
    if (p.coverage < COVERAGE_MID) begin
      shade = GRAY_COLOR;
    end else begin
      k = int'(p.glyph_row) / 3;
      if (k > PAL_LAST) k = PAL_LAST;
      for (int lane = 0; lane < 4; lane++) begin
        shade[lane*8 +: 8] = blend_lane(int'(grad_start[lane*8 +: 8]),
                                        int'(grad_end[lane*8 +: 8]), k);
      end
    end
    w.addr  = ADDR_W'(sy * SCREEN_WIDTH + sx);
    w.color = shade;
    return 1'b1;
  endfunction

  function automatic glyph_pixel_t make_pixel(input int ox, input int oy, input int col,
                                              input int row, input int cov);
    glyph_pixel_t p;
    p.origin_x  = ORIGIN_W'(ox);
    p.origin_y  = ORIGIN_W'(oy);
    p.glyph_col = GLYPH_W'(col);
    p.glyph_row = GLYPH_W'(row);
    p.coverage  = COV_W'(cov);
    return p;
  endfunction

  task automatic send_pixel(input glyph_pixel_t p, output bit writes);
    pixel_write_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_origin_x  <= p.origin_x;
    in_origin_y  <= p.origin_y;
    in_glyph_col <= p.glyph_col;
    in_glyph_row <= p.glyph_row;
    in_coverage  <= p.coverage;
    do @(posedge clk); while (in_ready !== 1'b1);
    writes = predict_write(p, w);
    if (writes) pending_writes.push_back(w);
  endtask

  task automatic send_list(input glyph_pixel_t list[$]);
    bit writes;
    foreach (list[i]) send_pixel(list[i], writes);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(input cfg_reg_t idx, input logic [COLOR_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_COLOR: grad_start = value;
      REG_END_COLOR:   grad_end = value;
      default: ;
    endcase
  endtask

  // transaction check: oldest pending write against each accepted result
  always @(posedge clk) begin : pixel_sink
    pixel_write_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected write address", 32'(out_pixel_address), 32'h0);
      end else begin
        want = pending_writes.pop_front();
        if (out_pixel_address !== want.addr)
          report_mismatch("pixel_address", 32'(out_pixel_address), 32'(want.addr));
        if (out_pixel_color !== want.color)
          report_mismatch("pixel_color", out_pixel_color, want.color);
      end
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic test_reset_gradient();
    glyph_pixel_t list[$];
    list.push_back(make_pixel(100, 100, 0, 0, 200));
    list.push_back(make_pixel(100, 100, 1, 5, 129));
    list.push_back(make_pixel(100, 100, 2, 20, 255));
    list.push_back(make_pixel(100, 100, 3, 21, 255));
    list.push_back(make_pixel(100, 100, 4, 255, 255));
    send_list(list);
  endtask

  task automatic test_coverage_classes();
    glyph_pixel_t list[$];
    list.push_back(make_pixel(500, 300, 7, 9, 0));
    list.push_back(make_pixel(500, 300, 7, 9, 1));
    list.push_back(make_pixel(500, 300, 7, 9, 127));
    list.push_back(make_pixel(500, 300, 7, 9, 128));
    list.push_back(make_pixel(500, 300, 7, 9, 129));
    list.push_back(make_pixel(500, 300, 7, 9, 255));
    send_list(list);
  endtask

  task automatic test_screen_clipping();
    glyph_pixel_t list[$];
    list.push_back(make_pixel(-4096, -4096, 255, 255, 255));
    list.push_back(make_pixel(4095, 4095, 0, 0, 255));
    list.push_back(make_pixel(-1, 0, 0, 0, 255));
    list.push_back(make_pixel(-1, 0, 1, 0, 64));
    list.push_back(make_pixel(SCREEN_WIDTH - 256, SCREEN_HEIGHT - 256, 255, 255, 255));
    list.push_back(make_pixel(SCREEN_WIDTH - 255, 10, 255, 0, 255));
    list.push_back(make_pixel(10, SCREEN_HEIGHT - 255, 0, 255, 100));
    send_list(list);
  endtask

  task automatic test_palette_extremes();
    glyph_pixel_t list[$];
    write_color(REG_START_COLOR, 32'h0000_0000);
    write_color(REG_END_COLOR, 32'hFFFF_FFFF);
    list.push_back(make_pixel(0, 0, 0, 0, 255));
    list.push_back(make_pixel(0, 0, 0, 12, 200));
    list.push_back(make_pixel(0, 0, 0, 21, 255));
    send_list(list);
    list.delete();
    write_color(REG_START_COLOR, 32'hFFFF_FFFF);
    write_color(REG_END_COLOR, 32'h0000_0000);
    list.push_back(make_pixel(SCREEN_WIDTH - 1, 0, 0, 0, 255));
    list.push_back(make_pixel(0, 800, 0, 12, 130));
    list.push_back(make_pixel(0, 800, 0, 255, 255));
    send_list(list);
  endtask

  task automatic test_random_pixels(input int target_writes, input int send_pct,
                                    input int stall_pct);
    int written;
    int ox;
    int oy;
    int span;
    int burst;
    bit writes;
    written = 0;
    write_color(REG_START_COLOR, $urandom());
    write_color(REG_END_COLOR, $urandom());
    send_idle_pct  = send_pct;
    sink_stall_pct = stall_pct;
    while (written < target_writes) begin
      if ($urandom_range(99) < 15) begin
        send_pixel(make_pixel($urandom_range(8191), $urandom_range(8191), $urandom_range(255),
                              $urandom_range(255), $urandom_range(255)), writes);
        if (writes) written++;
      end else begin
        ox    = int'($urandom_range(SCREEN_WIDTH + 40)) - 40;
        oy    = int'($urandom_range(SCREEN_HEIGHT + 40)) - 40;
        span  = ($urandom_range(7) == 0) ? 255 : $urandom_range(40, 3);
        burst = $urandom_range(12, 4);
        repeat (burst) begin
          send_pixel(make_pixel(ox, oy, $urandom_range(span), $urandom_range(span),
                                $urandom_range(255)), writes);
          if (writes) written++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_gradient();
    test_coverage_classes();
    test_screen_clipping();
    test_palette_extremes();
    test_random_pixels(170, 30, 63);
    test_random_pixels(170, 63, 30);
    test_random_pixels(170, 0, 0);
    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
